// File: hdl/sai_pkg.sv
// Shared types and constants for the segment angle block.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package sai_pkg;

  // Fixed widths of the interface fields
  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 18;

  // CORDIC datapath
  localparam int ACC_FRAC     = 20;
  localparam int CORDIC_STEPS = 27;
  localparam int NORM_TOP     = 40;
  localparam int NORM_STAGES  = $clog2(COORD_BITS);
  localparam int XY_W         = NORM_TOP + 3;
  localparam int Z_W          = ACC_FRAC + 8;
  localparam int T_W          = ANGLE_FRAC_BITS + 7;
  localparam int CALC_W       = (ANGLE_FRAC_BITS + 10 > ANGLE_W) ?
                                ANGLE_FRAC_BITS + 10 : ANGLE_W;
  localparam int ROUND_SH     = ACC_FRAC - ANGLE_FRAC_BITS;

  // Request queue between front and back
  localparam int FIFO_DEPTH = 2;

  // Pipeline depth from an accepted request to its done strobe
  localparam int LATENCY = NORM_STAGES + CORDIC_STEPS + 5;

  localparam logic signed [Z_W-1:0] Z_RIGHT    = Z_W'(90 * (2 ** ACC_FRAC));
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(2 ** (ROUND_SH - 1));
  localparam logic [T_W-1:0]        T_RIGHT    = T_W'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [CALC_W-1:0]     D180       = CALC_W'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [CALC_W-1:0]     D360       = CALC_W'(360 * (2 ** ANGLE_FRAC_BITS));

  // atan(2^-i) in degrees, 2^-20 degree units
  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    Z_W'(47185920), Z_W'(27855475), Z_W'(14718068), Z_W'(7471121), Z_W'(3750058),
    Z_W'(1876857),  Z_W'(938658),   Z_W'(469357),   Z_W'(234682),  Z_W'(117342),
    Z_W'(58671),    Z_W'(29335),    Z_W'(14668),    Z_W'(7334),    Z_W'(3667),
    Z_W'(1833),     Z_W'(917),      Z_W'(458),      Z_W'(229),     Z_W'(115),
    Z_W'(57),       Z_W'(29),       Z_W'(14),       Z_W'(7),       Z_W'(4),
    Z_W'(2),        Z_W'(1)
  };

  typedef enum logic [1:0] {
    MODE_FOLD   = 2'd0,  // [-90,90]
    MODE_MOD180 = 2'd1,  // [0,180)
    MODE_FULL   = 2'd2,  // [0,360)
    MODE_ZERO   = 2'd3   // always zero
  } range_mode_e;

  typedef enum logic [1:0] {
    KIND_DEGEN,
    KIND_VERT,
    KIND_HORIZ,
    KIND_OBLIQUE
  } seg_kind_e;

  typedef struct packed {
    seg_kind_e   kind;
    logic        dx_neg;
    logic        dy_neg;
    range_mode_e mode;
  } seg_ctrl_t;

  typedef struct packed {
    seg_ctrl_t             ctrl;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
  } seg_item_t;

endpackage

`default_nettype wire

// File: hdl/sai_front.sv
// Front end: takes a request, forms the end-point differences and classifies the segment.
// Depends on sai_pkg.
`default_nettype none

module sai_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] start_x_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] start_y_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] end_x_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] end_y_i,
  input  wire sai_pkg::range_mode_e                mode_i,
  input  wire logic                                full_i,
  output logic                                     busy_o,
  output logic                                     push_o,
  output sai_pkg::seg_item_t                       item_o
);

  localparam int D_W = sai_pkg::COORD_BITS + 1;

  logic signed [D_W-1:0] dx, dy, adx, ady;
  logic                  accept;
  logic                  valid_d, valid_q;
  sai_pkg::seg_item_t    item_d, item_q;

  assign dx = D_W'(end_x_i) - D_W'(start_x_i);
  assign dy = D_W'(end_y_i) - D_W'(start_y_i);
  assign adx = dx[D_W-1] ? -dx : dx;
  assign ady = dy[D_W-1] ? -dy : dy;

  always_comb begin
    item_d.ax          = adx[sai_pkg::COORD_BITS-1:0];
    item_d.ay          = ady[sai_pkg::COORD_BITS-1:0];
    item_d.ctrl.dx_neg = dx[D_W-1];
    item_d.ctrl.dy_neg = dy[D_W-1];
    item_d.ctrl.mode   = mode_i;
    priority if (dx == '0 && dy == '0) begin
      item_d.ctrl.kind = sai_pkg::KIND_DEGEN;
    end else if (dx == '0) begin
      item_d.ctrl.kind = sai_pkg::KIND_VERT;
    end else if (dy == '0) begin
      item_d.ctrl.kind = sai_pkg::KIND_HORIZ;
    end else begin
      item_d.ctrl.kind = sai_pkg::KIND_OBLIQUE;
    end
  end

  // holding register stalls only if the queue is full
  assign busy_o = valid_q && full_i;
  assign push_o = valid_q && !full_i;
  assign accept = start_i && !busy_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// File: hdl/sai_fifo.sv
// Short request queue between the front end and the CORDIC back end.
// Depends on sai_pkg.
`default_nettype none

module sai_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire sai_pkg::seg_item_t push_item_i,
  input  wire logic               pop_i,
  output sai_pkg::seg_item_t      pop_item_o,
  output logic                    full_o,
  output logic                    empty_o
);

  localparam int DEPTH = sai_pkg::FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sai_pkg::seg_item_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sai_back.sv
// Back end: normalise, pipelined CORDIC vectoring, round, place into the range.
// Depends on sai_pkg.
`default_nettype none

module sai_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire sai_pkg::seg_item_t          item_i,
  output logic                             done_o,
  output logic [sai_pkg::ANGLE_W-1:0]      angle_o,
  output logic                             degen_o
);

  localparam int NS    = sai_pkg::NORM_STAGES;
  localparam int STEPS = sai_pkg::CORDIC_STEPS;
  localparam int TOP   = sai_pkg::NORM_TOP;
  localparam int XY_W  = sai_pkg::XY_W;
  localparam int Z_W   = sai_pkg::Z_W;
  localparam int T_W   = sai_pkg::T_W;

  // ---- normalisation: larger magnitude brought into [2^39, 2^40) ----
  logic [NS:0]         nv_q;
  sai_pkg::seg_ctrl_t  nc_q [NS+1];
  logic [TOP-1:0]      nx_q [NS+1];
  logic [TOP-1:0]      ny_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
    end else begin
      nv_q <= {nv_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    nc_q[0] <= item_i.ctrl;
    nx_q[0] <= TOP'(item_i.ax) << (TOP - sai_pkg::COORD_BITS);
    ny_q[0] <= TOP'(item_i.ay) << (TOP - sai_pkg::COORD_BITS);
  end

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 2 ** (NS - 1 - k);
    logic top_zero;
    assign top_zero = ~|((nx_q[k] | ny_q[k]) >> (TOP - SH));
    always_ff @(posedge clk_i) begin
      nc_q[k+1] <= nc_q[k];
      nx_q[k+1] <= top_zero ? nx_q[k] << SH : nx_q[k];
      ny_q[k+1] <= top_zero ? ny_q[k] << SH : ny_q[k];
    end
  end

  // ---- CORDIC vectoring, one micro-rotation per stage ----
  logic [STEPS-1:0]         cv_q;
  sai_pkg::seg_ctrl_t       cc_q [STEPS];
  logic signed [XY_W-1:0]   cx_q [STEPS];
  logic signed [XY_W-1:0]   cy_q [STEPS];
  logic signed [Z_W-1:0]    cz_q [STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      cv_q <= {cv_q[STEPS-2:0], nv_q[NS]};
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    sai_pkg::seg_ctrl_t     c_in;
    logic signed [XY_W-1:0] x_in, y_in;
    logic signed [Z_W-1:0]  z_in;
    if (i == 0) begin : g_first
      always_comb begin
        c_in = nc_q[NS];
        x_in = XY_W'(nx_q[NS]);
        y_in = XY_W'(ny_q[NS]);
        z_in = '0;
      end
    end else begin : g_next
      always_comb begin
        c_in = cc_q[i-1];
        x_in = cx_q[i-1];
        y_in = cy_q[i-1];
        z_in = cz_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      cc_q[i] <= c_in;
      if (y_in > 0) begin
        cx_q[i] <= x_in + (y_in >>> i);
        cy_q[i] <= y_in - (x_in >>> i);
        cz_q[i] <= z_in + sai_pkg::ATAN_TAB[i];
      end else begin
        cx_q[i] <= x_in - (y_in >>> i);
        cy_q[i] <= y_in + (x_in >>> i);
        cz_q[i] <= z_in - sai_pkg::ATAN_TAB[i];
      end
    end
  end

  // ---- clamp, round, axis override ----
  logic signed [Z_W-1:0] z_clamp, z_round;
  logic [T_W-1:0]        t_round, t_d, t_q;
  logic                  tv_q;
  sai_pkg::seg_ctrl_t    tc_q;

  always_comb begin
    priority if (cz_q[STEPS-1] < 0) begin
      z_clamp = '0;
    end else if (cz_q[STEPS-1] > sai_pkg::Z_RIGHT) begin
      z_clamp = sai_pkg::Z_RIGHT;
    end else begin
      z_clamp = cz_q[STEPS-1];
    end
    z_round = z_clamp + sai_pkg::ROUND_HALF;
    t_round = T_W'(z_round >>> sai_pkg::ROUND_SH);
    if (t_round == '0) begin
      t_round = T_W'(1);  // oblique segment never rounds down to the horizontal axis
    end
    unique case (cc_q[STEPS-1].kind)
      sai_pkg::KIND_VERT:    t_d = sai_pkg::T_RIGHT;
      sai_pkg::KIND_OBLIQUE: t_d = t_round;
      default:               t_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else begin
      tv_q <= cv_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    tc_q <= cc_q[STEPS-1];
  end

  // ---- quadrant placement ----
  logic [sai_pkg::CALC_W-1:0] t_ext, ang;
  logic                       dy_pos, degen;
  logic                       done_q, degen_q;
  logic [sai_pkg::ANGLE_W-1:0] angle_q;

  assign t_ext  = sai_pkg::CALC_W'(t_q);
  assign degen  = (tc_q.kind == sai_pkg::KIND_DEGEN);
  assign dy_pos = !tc_q.dy_neg && (tc_q.kind == sai_pkg::KIND_OBLIQUE ||
                                   tc_q.kind == sai_pkg::KIND_VERT);

  always_comb begin
    priority if (degen || tc_q.mode == sai_pkg::MODE_ZERO) begin
      ang = '0;
    end else if (!tc_q.dx_neg && !tc_q.dy_neg) begin
      ang = t_ext;
    end else if (tc_q.dx_neg && dy_pos) begin
      ang = (tc_q.mode == sai_pkg::MODE_FOLD) ? '0 - t_ext : sai_pkg::D180 - t_ext;
    end else if (tc_q.dx_neg) begin
      ang = (tc_q.mode == sai_pkg::MODE_FULL) ? sai_pkg::D180 + t_ext : t_ext;
    end else begin
      unique case (tc_q.mode)
        sai_pkg::MODE_FOLD:   ang = '0 - t_ext;
        sai_pkg::MODE_MOD180: ang = sai_pkg::D180 - t_ext;
        sai_pkg::MODE_FULL:   ang = sai_pkg::D360 - t_ext;
        default:              ang = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= ang[sai_pkg::ANGLE_W-1:0];
    degen_q <= degen;
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;
  assign degen_o = degen_q;

endmodule

`default_nettype wire

// File: hdl/segment_angle_in_range.sv
// Top level of the segment angle block: range register, front end, queue, back end.
// Depends on sai_pkg, sai_front, sai_fifo and sai_back.
`default_nettype none

// Segment angle unit. Pulse start_i with the two end points while busy_o is low
// and, after the pipeline below, done_o is high for exactly one cycle with
// angle_q8_o (degrees, two's complement, 8 fraction bits) and degenerate_o.
// One segment is taken every clock. The latency is the front-end holding
// register, one queue slot, the back end's input register, four normalisation
// stages, the 27-stage CORDIC pipeline and the rounding and output registers.
// The result cannot be held off:
// capture it in the cycle done_o is high. range_mode (cfg_wdata_i written with
// cfg_we_i) picks [-90,90], [0,180), [0,360) or a constant zero; change it only
// when no request is in flight, since each request takes the mode at accept.

module segment_angle_in_range (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [1:0]                            cfg_wdata_i,
  // request
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] start_x_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] start_y_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] end_x_i,
  input  wire logic signed [sai_pkg::COORD_BITS-1:0] end_y_i,
  // result
  output logic                                       done_o,
  output logic signed [sai_pkg::ANGLE_W-1:0]         angle_q8_o,
  output logic                                       degenerate_o
);

  sai_pkg::range_mode_e range_mode_q;

  sai_pkg::seg_item_t front_item, back_item;
  logic               push, fifo_full, fifo_empty, back_valid;
  logic [sai_pkg::ANGLE_W-1:0] angle;

  // range register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_mode_q <= sai_pkg::MODE_FOLD;
    end else if (cfg_we_i) begin
      range_mode_q <= sai_pkg::range_mode_e'(cfg_wdata_i);
    end
  end

  // front end: differences, magnitudes, segment class
  sai_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .mode_i    (range_mode_q),
    .full_i    (fifo_full),
    .busy_o    (busy_o),
    .push_o    (push),
    .item_o    (front_item)
  );

  // request queue; the back end drains it every cycle
  sai_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .pop_i       (back_valid),
    .pop_item_o  (back_item),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  assign back_valid = !fifo_empty;

  // back end: fully pipelined, never stalls
  sai_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (back_valid),
    .item_i  (back_item),
    .done_o  (done_o),
    .angle_o (angle),
    .degen_o (degenerate_o)
  );

  assign angle_q8_o = angle;

  // ---- assertions ----
  logic accept;
  assign accept = start_i && !busy_o;

  // back end drains a request every clock, so the queue never fills
  a_queue_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_full)
    else $error("request queue filled up");

  // every accepted request completes after the fixed latency
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(sai_pkg::LATENCY) done_o)
    else $error("done strobe missing after accepted request");

  // no result without a matching request
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, sai_pkg::LATENCY))
    else $error("done strobe without a request");

  // a zero-length segment always reports a zero angle
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (angle_q8_o == '0))
    else $error("degenerate segment with nonzero angle");

endmodule

`default_nettype wire
